/* src/fvr_pkg.sv */
// Package for the flocking velocity rules core: shared types, constants and
// saturation helpers. No dependencies.
`default_nettype none
package fvr_pkg;

  localparam int FLOCK_MEMBERS_DEF = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int POS_W = 24;
  localparam int MIGRATION_GAIN = 66;
  localparam int DIV_NUM_W = 34;
  localparam int DIV_DEN_W = 25;

  localparam logic signed [POS_W-1:0] MAX24 = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] MIN24 = -24'sh800000;

  localparam logic [2:0] REG_SELF_INDEX  = 3'd0;
  localparam logic [2:0] REG_TARGET_X    = 3'd1;
  localparam logic [2:0] REG_TARGET_Z    = 3'd2;
  localparam logic [2:0] REG_COH_WEIGHT  = 3'd3;
  localparam logic [2:0] REG_DISP_WEIGHT = 3'd4;
  localparam logic [2:0] REG_ALIGN_WEIGHT = 3'd5;
  localparam logic [2:0] REG_COH_RADIUS  = 3'd6;
  localparam logic [2:0] REG_SEP_LIMIT   = 3'd7;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_STEER  = 1'b1;

  typedef struct packed {
    logic [2:0]              self_index;
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_z;
    logic [15:0]             cohesion_weight;
    logic [15:0]             dispersion_weight;
    logic [15:0]             alignment_weight;
    logic [15:0]             cohesion_radius;
    logic [15:0]             separation_limit;
  } cfg_t;

  typedef struct packed {
    logic                    operation;
    logic [2:0]              member;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
  } item_t;

  function automatic logic over24(input logic signed [47:0] v);
    over24 = (v > 48'(MAX24)) || (v < 48'(MIN24));
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [47:0] v);
    if (v > 48'(MAX24)) begin
      sat24 = MAX24;
    end else if (v < 48'(MIN24)) begin
      sat24 = MIN24;
    end else begin
      sat24 = v[POS_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* src/fvr_if.sv */
// Channel interfaces of the flocking velocity rules core: request in, result out.
// Depends on nothing.
`default_nettype none
interface fvr_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [2:0]         member;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_z;
  modport source (output valid, operation, member, pos_x, pos_z, input ready);
  modport sink   (input valid, operation, member, pos_x, pos_z, output ready);
endinterface

interface fvr_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] speed_x;
  logic signed [23:0] speed_z;
  logic               saturated;
  modport source (output valid, speed_x, speed_z, saturated, input ready);
  modport sink   (input valid, speed_x, speed_z, saturated, output ready);
endinterface
`default_nettype wire

/* src/fvr_div.sv */
// Restoring divider, one quotient bit per cycle, used for the dispersion reciprocals.
// Depends on fvr_pkg for default widths.
`default_nettype none
module fvr_div #(
  parameter int NUM_W = fvr_pkg::DIV_NUM_W,
  parameter int DEN_W = fvr_pkg::DIV_DEN_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);
  localparam int CW = $clog2(NUM_W);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] qs;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, qs[NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_r};
    rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        qs    <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= rem_next;
        qs  <= {qs[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = qs;
endmodule
`default_nettype wire

/* src/fvr_front.sv */
// Front part: accepts requests, drops updates of members outside the table and
// queues the rest for the back part. Depends on fvr_pkg and fvr_if.
`default_nettype none
module fvr_front #(
  parameter int FLOCK_MEMBERS = fvr_pkg::FLOCK_MEMBERS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  fvr_in_if.sink       in_ch,
  output fvr_pkg::item_t head,
  output logic         head_valid,
  input  wire logic    pop
);
  import fvr_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t        q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          accept;
  logic          keep;
  logic          push;
  logic          do_pop;

  always_comb begin
    in_ch.ready = count < (PW+1)'(QUEUE_DEPTH);
    accept      = in_ch.valid && in_ch.ready;
    keep        = (in_ch.operation == OP_STEER) || ({2'b00, in_ch.member} < 5'(FLOCK_MEMBERS));
    push        = accept && keep;
    head_valid  = count != '0;
    do_pop      = pop && head_valid;
    head        = q[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q[wr_ptr] <= '{operation: in_ch.operation, member: in_ch.member,
                       pos_x: in_ch.pos_x, pos_z: in_ch.pos_z};
        wr_ptr    <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

/* src/fvr_back.sv */
// Back part: member table, update of positions and speeds, and the steering
// sequencer with its shared divider and multiplier. Depends on fvr_pkg, fvr_div.
`default_nettype none
module fvr_back #(
  parameter int FLOCK_MEMBERS = fvr_pkg::FLOCK_MEMBERS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire fvr_pkg::cfg_t  cfg,
  input  wire fvr_pkg::item_t head,
  input  wire logic           head_valid,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic signed [23:0]  out_speed_x,
  output logic signed [23:0]  out_speed_z,
  output logic                out_saturated
);
  import fvr_pkg::*;

  localparam int IW = $clog2(FLOCK_MEMBERS);
  localparam int SW = POS_W + IW + 1;
  localparam int OTHERS = FLOCK_MEMBERS - 1;
  localparam int HALF = OTHERS / 2;

  // Averages divide by the member count less one through a multiply by the
  // rounded-up reciprocal; this is exact for every numerator below 2^AVG_NW.
  localparam int AVG_NW = POS_W + IW;
  localparam int AVG_SH = AVG_NW + 4;
  localparam int AVG_MW = AVG_SH + 1;
  localparam int AVG_PW = AVG_NW + AVG_MW;
  localparam logic [AVG_MW-1:0] AVG_MUL =
    AVG_MW'(((64'd1 << AVG_SH) + 64'(OTHERS - 1)) / 64'(OTHERS));

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_OWN      = 15'b000000000000010,
    S_SUM      = 15'b000000000000100,
    S_AVG_GO   = 15'b000000000001000,
    S_AVG_WAIT = 15'b000000000010000,
    S_COH_D    = 15'b000000000100000,
    S_COH_SQ   = 15'b000000001000000,
    S_COH_CMP  = 15'b000000010000000,
    S_DSP_D    = 15'b000000100000000,
    S_DSP_SQ   = 15'b000001000000000,
    S_DSP_CMP  = 15'b000010000000000,
    S_RCP_GO   = 15'b000100000000000,
    S_RCP_WAIT = 15'b001000000000000,
    S_MUL      = 15'b010000000000000,
    S_FIN      = 15'b100000000000000
  } state_t;

  state_t state;

  logic signed [POS_W-1:0] pos_x_mem [FLOCK_MEMBERS];
  logic signed [POS_W-1:0] pos_z_mem [FLOCK_MEMBERS];
  logic signed [POS_W-1:0] prv_x_mem [FLOCK_MEMBERS];
  logic signed [POS_W-1:0] prv_z_mem [FLOCK_MEMBERS];
  logic signed [POS_W-1:0] spd_x_mem [FLOCK_MEMBERS];
  logic signed [POS_W-1:0] spd_z_mem [FLOCK_MEMBERS];
  logic [FLOCK_MEMBERS-1:0] heard;

  logic [IW-1:0] k;
  logic [IW-1:0] s;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] mem_idx;
  logic [1:0]    a;
  logic          r;
  logic [3:0]    t;
  logic          dneg;
  logic          flag;

  logic signed [POS_W-1:0] own_x, own_z, own_sx, own_sz;
  logic signed [POS_W-1:0] avg_px, avg_pz, avg_sx, avg_sz;
  logic signed [SW-1:0]    sum_px, sum_pz, sum_sx, sum_sz;
  logic signed [SW-1:0]    disp_x, disp_z;
  logic signed [POS_W:0]   d_x, d_z;
  logic signed [POS_W:0]   coh_x, coh_z;
  logic [2*POS_W+1:0]      sq_x, sq_z;
  logic [31:0]             r2;
  logic signed [47:0]      acc_x, acc_z, prod;

  logic signed [POS_W-1:0] rd_px, rd_pz, rd_sx, rd_sz;
  logic signed [POS_W-1:0] new_prv_x, new_prv_z;
  logic signed [POS_W:0]   dif_x, dif_z;
  logic signed [47:0]      upd_x, upd_z;
  logic                    near;
  logic                    is_last;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  logic signed [SW-1:0]    avg_sel;
  logic [SW-1:0]           avg_mag;
  logic [AVG_NW-1:0]       avg_num;
  logic [AVG_PW-1:0]       avg_prod;
  logic [POS_W:0]          avg_q;
  logic signed [POS_W:0]   rcp_d;
  logic [POS_W:0]          rcp_mag;
  logic signed [POS_W:0]   q_signed;
  logic signed [POS_W:0]   rcp_val;

  logic signed [25:0]      mul_a;
  logic signed [16:0]      mul_b;
  logic signed [POS_W-1:0] dsat_x, dsat_z;
  logic signed [47:0]      rnd_x, rnd_z;

  fvr_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    s = ({2'b00, cfg.self_index} >= 5'(FLOCK_MEMBERS)) ? IW'(FLOCK_MEMBERS - 1)
                                                     : IW'(cfg.self_index);
    mem_idx = IW'(head.member);
    case (state)
      S_IDLE:  rd_idx = mem_idx;
      S_OWN:   rd_idx = s;
      default: rd_idx = k;
    endcase
    rd_px = pos_x_mem[rd_idx];
    rd_pz = pos_z_mem[rd_idx];
    rd_sx = spd_x_mem[rd_idx];
    rd_sz = spd_z_mem[rd_idx];
    is_last = k == IW'(FLOCK_MEMBERS - 1);

    // Update: first report of a member has no previous position of its own.
    new_prv_x = heard[mem_idx] ? rd_px : head.pos_x;
    new_prv_z = heard[mem_idx] ? rd_pz : head.pos_z;
    dif_x = (POS_W+1)'(head.pos_x) - (POS_W+1)'(new_prv_x);
    dif_z = (POS_W+1)'(head.pos_z) - (POS_W+1)'(new_prv_z);
    upd_x = (48'(dif_x) * 48'sd125 + 48'sd4) >>> 3;
    upd_z = (48'(dif_z) * 48'sd125 + 48'sd4) >>> 3;

    case (a)
      2'd0:    avg_sel = sum_px;
      2'd1:    avg_sel = sum_pz;
      2'd2:    avg_sel = sum_sx;
      default: avg_sel = sum_sz;
    endcase
    avg_mag = avg_sel[SW-1] ? SW'(-avg_sel) : SW'(avg_sel);
    avg_num = AVG_NW'(avg_mag) + AVG_NW'(HALF);
    avg_q   = (POS_W+1)'(avg_prod >> AVG_SH);

    rcp_d   = r ? d_z : d_x;
    rcp_mag = rcp_d[POS_W] ? (POS_W+1)'(-rcp_d) : (POS_W+1)'(rcp_d);

    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == S_RCP_GO && rcp_d != '0) begin
      div_start = 1'b1;
      div_num   = (DIV_NUM_W'(1) << 32) + DIV_NUM_W'(rcp_mag >> 1);
      div_den   = DIV_DEN_W'(rcp_mag);
    end

    q_signed = dneg ? -avg_q : avg_q;
    rcp_val  = (div_quot > DIV_NUM_W'(MAX24)) ? (POS_W+1)'(MAX24) : (POS_W+1)'(div_quot);
    rcp_val  = dneg ? -rcp_val : rcp_val;

    near = (sq_x + sq_z) < ((2*POS_W+2)'(cfg.separation_limit) << 16);

    dsat_x = sat24(48'(disp_x));
    dsat_z = sat24(48'(disp_z));
    case (t[2:1])
      2'd0: begin
        mul_a = t[0] ? 26'(coh_z) : 26'(coh_x);
        mul_b = {1'b0, cfg.cohesion_weight};
      end
      2'd1: begin
        mul_a = t[0] ? 26'(dsat_z) : 26'(dsat_x);
        mul_b = {1'b0, cfg.dispersion_weight};
      end
      2'd2: begin
        mul_a = t[0] ? 26'(avg_sz) - 26'(own_sz) : 26'(avg_sx) - 26'(own_sx);
        mul_b = {1'b0, cfg.alignment_weight};
      end
      default: begin
        mul_a = t[0] ? 26'(cfg.target_z) - 26'(own_z) : 26'(cfg.target_x) - 26'(own_x);
        mul_b = 17'(MIGRATION_GAIN);
      end
    endcase

    rnd_x = (acc_x + 48'sd32768) >>> 16;
    rnd_z = (-acc_z + 48'sd32768) >>> 16;

    pop = (state == S_IDLE) && head_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      heard     <= '0;
      for (int i = 0; i < FLOCK_MEMBERS; i++) begin
        pos_x_mem[i] <= '0;
        pos_z_mem[i] <= '0;
        prv_x_mem[i] <= '0;
        prv_z_mem[i] <= '0;
        spd_x_mem[i] <= '0;
        spd_z_mem[i] <= '0;
      end
    end else begin
      // The final step reloads the output register itself when it fires.
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            if (head.operation == OP_UPDATE) begin
              heard[mem_idx]     <= 1'b1;
              prv_x_mem[mem_idx] <= new_prv_x;
              prv_z_mem[mem_idx] <= new_prv_z;
              pos_x_mem[mem_idx] <= head.pos_x;
              pos_z_mem[mem_idx] <= head.pos_z;
              spd_x_mem[mem_idx] <= sat24(upd_x);
              spd_z_mem[mem_idx] <= sat24(upd_z);
            end else begin
              state <= S_OWN;
            end
          end
        end
        S_OWN: begin
          own_x  <= rd_px;
          own_z  <= rd_pz;
          own_sx <= rd_sx;
          own_sz <= rd_sz;
          sum_px <= '0;
          sum_pz <= '0;
          sum_sx <= '0;
          sum_sz <= '0;
          disp_x <= '0;
          disp_z <= '0;
          acc_x  <= '0;
          acc_z  <= '0;
          flag   <= 1'b0;
          k      <= '0;
          state  <= S_SUM;
        end
        S_SUM: begin
          if (k != s) begin
            sum_px <= sum_px + SW'(rd_px);
            sum_pz <= sum_pz + SW'(rd_pz);
            sum_sx <= sum_sx + SW'(rd_sx);
            sum_sz <= sum_sz + SW'(rd_sz);
          end
          k <= k + 1'b1;
          if (is_last) begin
            a     <= 2'd0;
            state <= S_AVG_GO;
          end
        end
        S_AVG_GO: begin
          avg_prod <= AVG_PW'(avg_num) * AVG_PW'(AVG_MUL);
          dneg     <= avg_sel[SW-1];
          state    <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          case (a)
            2'd0:    avg_px <= q_signed[POS_W-1:0];
            2'd1:    avg_pz <= q_signed[POS_W-1:0];
            2'd2:    avg_sx <= q_signed[POS_W-1:0];
            default: avg_sz <= q_signed[POS_W-1:0];
          endcase
          a     <= a + 1'b1;
          state <= (a == 2'd3) ? S_COH_D : S_AVG_GO;
        end
        S_COH_D: begin
          d_x   <= (POS_W+1)'(avg_px) - (POS_W+1)'(own_x);
          d_z   <= (POS_W+1)'(avg_pz) - (POS_W+1)'(own_z);
          state <= S_COH_SQ;
        end
        S_COH_SQ: begin
          sq_x  <= (2*POS_W+2)'(d_x) * (2*POS_W+2)'(d_x);
          sq_z  <= (2*POS_W+2)'(d_z) * (2*POS_W+2)'(d_z);
          r2    <= cfg.cohesion_radius * cfg.cohesion_radius;
          state <= S_COH_CMP;
        end
        S_COH_CMP: begin
          if ((sq_x + sq_z) > (2*POS_W+2)'(r2)) begin
            coh_x <= d_x;
            coh_z <= d_z;
          end else begin
            coh_x <= '0;
            coh_z <= '0;
          end
          k     <= '0;
          state <= S_DSP_D;
        end
        S_DSP_D: begin
          d_x <= (POS_W+1)'(own_x) - (POS_W+1)'(rd_px);
          d_z <= (POS_W+1)'(own_z) - (POS_W+1)'(rd_pz);
          if (k == s) begin
            k     <= k + 1'b1;
            state <= is_last ? S_MUL : S_DSP_D;
            t     <= '0;
          end else begin
            state <= S_DSP_SQ;
          end
        end
        S_DSP_SQ: begin
          sq_x  <= (2*POS_W+2)'(d_x) * (2*POS_W+2)'(d_x);
          sq_z  <= (2*POS_W+2)'(d_z) * (2*POS_W+2)'(d_z);
          state <= S_DSP_CMP;
        end
        S_DSP_CMP: begin
          r <= 1'b0;
          t <= '0;
          if (near) begin
            state <= S_RCP_GO;
          end else begin
            k     <= k + 1'b1;
            state <= is_last ? S_MUL : S_DSP_D;
          end
        end
        S_RCP_GO: begin
          dneg <= rcp_d[POS_W];
          if (rcp_d == '0) begin
            // A zero difference gives the largest positive reciprocal.
            flag <= 1'b1;
            if (r) begin
              disp_z <= disp_z + SW'(MAX24);
              k      <= k + 1'b1;
              state  <= is_last ? S_MUL : S_DSP_D;
            end else begin
              disp_x <= disp_x + SW'(MAX24);
              r      <= 1'b1;
            end
          end else begin
            state <= S_RCP_WAIT;
          end
        end
        S_RCP_WAIT: begin
          if (div_done) begin
            if (div_quot > DIV_NUM_W'(MAX24)) begin
              flag <= 1'b1;
            end
            if (r) begin
              disp_z <= disp_z + SW'(rcp_val);
              k      <= k + 1'b1;
              state  <= is_last ? S_MUL : S_DSP_D;
            end else begin
              disp_x <= disp_x + SW'(rcp_val);
              r      <= 1'b1;
              state  <= S_RCP_GO;
            end
          end
        end
        S_MUL: begin
          prod <= 48'(mul_a) * 48'(mul_b);
          if (t == 4'd0) begin
            if (over24(48'(disp_x)) || over24(48'(disp_z))) begin
              flag <= 1'b1;
            end
          end else if (t[0]) begin
            acc_x <= acc_x + prod;
          end else begin
            acc_z <= acc_z + prod;
          end
          t <= t + 1'b1;
          if (t == 4'd8) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            out_speed_x   <= sat24(rnd_x);
            out_speed_z   <= sat24(rnd_z);
            out_saturated <= flag || over24(rnd_x) || over24(rnd_z);
            spd_x_mem[s]  <= sat24(rnd_x);
            spd_z_mem[s]  <= sat24(rnd_z);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");
  a_res_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result raised outside the final step");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) pop |-> state == S_IDLE)
    else $error("queue popped while a steer is in progress");

endmodule
`default_nettype wire

/* src/flocking_velocity_rules_core.sv */
// Top level of the flocking velocity rules core: configuration registers,
// front part, back part. Depends on fvr_pkg, fvr_if, fvr_front, fvr_back.
//
// Requests arrive on in_ch. An update request (operation 0) stores a member's
// x/z position and derives its speed; it gives no result. Updates of members
// outside the table are accepted and dropped. A steer request (operation 1)
// walks the member table and returns one result on out_ch with the commanded
// speed and a saturation flag. The shared one-bit-per-cycle divider forms two
// reciprocals per close member, one per axis; an axis with a zero difference
// skips the divider. Each of the four averages passes through a multiply
// state and a capture state.
// A two-entry queue sits between the front and the back part, so requests are
// still taken while a steer is in progress until the queue is full.
// The result sits in an output register; while the receiver stalls it holds
// there, the back part waits at its final step and the queue fills.
// Configuration is written through cfg_we/cfg_index/cfg_data while the core
// is idle. Reset (synchronous, active high) clears the member table, the
// heard flags, the queue and the output, and loads the register defaults.
`default_nettype none
module flocking_velocity_rules_core #(
  parameter int FLOCK_MEMBERS = fvr_pkg::FLOCK_MEMBERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  fvr_in_if.sink           in_ch,
  fvr_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import fvr_pkg::*;

  cfg_t  cfg;
  item_t head;
  logic  head_valid;
  logic  pop;

  // Configuration registers; every index of the 3-bit field names one.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.self_index        <= 3'd0;
      cfg.target_x          <= '0;
      cfg.target_z          <= '0;
      cfg.cohesion_weight   <= 16'd3932;
      cfg.dispersion_weight <= 16'd131;
      cfg.alignment_weight  <= 16'd6554;
      cfg.cohesion_radius   <= 16'd13107;
      cfg.separation_limit  <= 16'd9830;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SELF_INDEX:   cfg.self_index        <= cfg_data[2:0];
        REG_TARGET_X:     cfg.target_x          <= cfg_data;
        REG_TARGET_Z:     cfg.target_z          <= cfg_data;
        REG_COH_WEIGHT:   cfg.cohesion_weight   <= cfg_data[15:0];
        REG_DISP_WEIGHT:  cfg.dispersion_weight <= cfg_data[15:0];
        REG_ALIGN_WEIGHT: cfg.alignment_weight  <= cfg_data[15:0];
        REG_COH_RADIUS:   cfg.cohesion_radius   <= cfg_data[15:0];
        REG_SEP_LIMIT:    cfg.separation_limit  <= cfg_data[15:0];
        default:          cfg.self_index        <= cfg.self_index;
      endcase
    end
  end

  // Front: takes requests and queues the ones with work to do.
  fvr_front #(.FLOCK_MEMBERS(FLOCK_MEMBERS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // Back: member table, updates and the steering sequencer.
  fvr_back #(.FLOCK_MEMBERS(FLOCK_MEMBERS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_speed_x   (out_ch.speed_x),
    .out_speed_z   (out_ch.speed_z),
    .out_saturated (out_ch.saturated)
  );
endmodule
`default_nettype wire

/* sim/fvr_flock_checker.sv */
// Checker for the flocking velocity rules core: watches the request, result
// and configuration ports, predicts each steer result and compares it.
// Depends on fvr_pkg and fvr_if.
`timescale 1ns / 1ps
module fvr_flock_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  fvr_in_if                in_ch,
  fvr_out_if               out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  import fvr_pkg::*;

  localparam int NMEM = FLOCK_MEMBERS_DEF;

  typedef struct {
    logic signed [23:0] speed_x;
    logic signed [23:0] speed_z;
    logic               saturated;
  } steer_result_t;

  steer_result_t steer_expected[$];

  longint member_pos[NMEM][2];
  longint member_prev[NMEM][2];
  longint member_speed[NMEM][2];
  bit     member_heard[NMEM];
  cfg_t   regs;

  assign pending = steer_expected.size();

  function automatic longint clamp24(input longint v, inout bit flag);
    if (v > 8388607) begin
      flag = 1'b1;
      return 8388607;
    end
    if (v < -8388608) begin
      flag = 1'b1;
      return -8388608;
    end
    return v;
  endfunction

  function automatic longint avg_round(input longint num);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + (NMEM - 1) / 2) / (NMEM - 1);
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint recip(input longint d, inout bit flag);
    longint mag, q;
    if (d == 0) begin
      flag = 1'b1;
      return 8388607;
    end
    mag = (d < 0) ? -d : d;
    q = ((64'sd1 <<< 32) + mag / 2) / mag;
    if (q > 8388607) begin
      flag = 1'b1;
      q = 8388607;
    end
    return (d < 0) ? -q : q;
  endfunction

  task automatic reset_model();
    for (int k = 0; k < NMEM; k++) begin
      for (int j = 0; j < 2; j++) begin
        member_pos[k][j] = 0;
        member_prev[k][j] = 0;
        member_speed[k][j] = 0;
      end
      member_heard[k] = 1'b0;
    end
    regs = '0;
    regs.cohesion_weight = 16'd3932;
    regs.dispersion_weight = 16'd131;
    regs.alignment_weight = 16'd6554;
    regs.cohesion_radius = 16'd13107;
    regs.separation_limit = 16'd9830;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    case (idx)
      REG_SELF_INDEX:   regs.self_index = data[2:0];
      REG_TARGET_X:     regs.target_x = data;
      REG_TARGET_Z:     regs.target_z = data;
      REG_COH_WEIGHT:   regs.cohesion_weight = data[15:0];
      REG_DISP_WEIGHT:  regs.dispersion_weight = data[15:0];
      REG_ALIGN_WEIGHT: regs.alignment_weight = data[15:0];
      REG_COH_RADIUS:   regs.cohesion_radius = data[15:0];
      default:          regs.separation_limit = data[15:0];
    endcase
  endtask

  task automatic update_member(input int m, input longint nx, input longint nz);
    bit dummy;
    dummy = 1'b0;
    if (m >= NMEM) return;
    if (!member_heard[m]) begin
      member_prev[m][0] = nx;
      member_prev[m][1] = nz;
      member_heard[m] = 1'b1;
    end else begin
      member_prev[m][0] = member_pos[m][0];
      member_prev[m][1] = member_pos[m][1];
    end
    member_pos[m][0] = nx;
    member_pos[m][1] = nz;
    for (int j = 0; j < 2; j++)
      member_speed[m][j] =
        clamp24(((member_pos[m][j] - member_prev[m][j]) * 125 + 4) >>> 3, dummy);
  endtask

  task automatic predict_steer();
    bit flag;
    int s;
    longint own[2], sum_p[2], sum_v[2], avg_p[2], avg_v[2];
    longint coh[2], disp[2], tgt[2], acc[2], res[2];
    longint dist2, dx, dz, rad;
    steer_result_t r;
    flag = 1'b0;
    s = (regs.self_index >= NMEM) ? NMEM - 1 : int'(regs.self_index);
    for (int j = 0; j < 2; j++) begin
      own[j] = member_pos[s][j];
      sum_p[j] = 0;
      sum_v[j] = 0;
      coh[j] = 0;
      disp[j] = 0;
    end
    for (int k = 0; k < NMEM; k++) begin
      if (k == s) continue;
      for (int j = 0; j < 2; j++) begin
        sum_p[j] += member_pos[k][j];
        sum_v[j] += member_speed[k][j];
      end
    end
    for (int j = 0; j < 2; j++) begin
      avg_p[j] = avg_round(sum_p[j]);
      avg_v[j] = avg_round(sum_v[j]);
    end
    // Cohesion only pulls once the center lies outside the radius.
    dist2 = (avg_p[0] - own[0]) * (avg_p[0] - own[0])
          + (avg_p[1] - own[1]) * (avg_p[1] - own[1]);
    rad = longint'(regs.cohesion_radius);
    if (dist2 > rad * rad) begin
      coh[0] = avg_p[0] - own[0];
      coh[1] = avg_p[1] - own[1];
    end
    for (int k = 0; k < NMEM; k++) begin
      if (k == s) continue;
      dx = own[0] - member_pos[k][0];
      dz = own[1] - member_pos[k][1];
      if (dx * dx + dz * dz < longint'(regs.separation_limit) * 65536) begin
        disp[0] += recip(dx, flag);
        disp[1] += recip(dz, flag);
      end
    end
    disp[0] = clamp24(disp[0], flag);
    disp[1] = clamp24(disp[1], flag);
    tgt[0] = longint'(regs.target_x);
    tgt[1] = longint'(regs.target_z);
    for (int j = 0; j < 2; j++)
      acc[j] = coh[j] * longint'(regs.cohesion_weight)
             + disp[j] * longint'(regs.dispersion_weight)
             + (avg_v[j] - member_speed[s][j]) * longint'(regs.alignment_weight)
             + (tgt[j] - own[j]) * MIGRATION_GAIN;
    acc[1] = -acc[1];
    for (int j = 0; j < 2; j++) begin
      res[j] = clamp24((acc[j] + 32768) >>> 16, flag);
      member_speed[s][j] = res[j];
    end
    r.speed_x = res[0][23:0];
    r.speed_z = res[1][23:0];
    r.saturated = flag;
    steer_expected.push_back(r);
  endtask

  task automatic report(input string what, input steer_result_t e, input steer_result_t a);
    if (fail_count < 10)
      $display("mismatch %s: expected x=%0d z=%0d sat=%0b, got x=%0d z=%0d sat=%0b",
               what, e.speed_x, e.speed_z, e.saturated, a.speed_x, a.speed_z,
               a.saturated);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    reset_model();
  end

  always @(posedge clk) begin
    steer_result_t got, want;
    if (rst) begin
      reset_model();
      steer_expected.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.speed_x = out_ch.speed_x;
        got.speed_z = out_ch.speed_z;
        got.saturated = out_ch.saturated;
        if (steer_expected.size() == 0) begin
          want = '{default: 0};
          report("unexpected result", want, got);
        end else begin
          want = steer_expected.pop_front();
          if (got.speed_x !== want.speed_x || got.speed_z !== want.speed_z ||
              got.saturated !== want.saturated)
            report("steer result", want, got);
        end
      end
      if (cfg_we)
        write_reg(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_STEER)
          predict_steer();
        else
          update_member(int'(in_ch.member), longint'(in_ch.pos_x),
                        longint'(in_ch.pos_z));
      end
    end
  end

  final begin
    if (steer_expected.size() != 0) begin
    end
  end
endmodule

/* sim/tb_flocking_velocity_rules_core.sv */
// Testbench top for the flocking velocity rules core: drives requests,
// configuration and result backpressure, and gives the verdict.
// Depends on fvr_pkg, fvr_if, fvr_flock_checker and the core itself.
`timescale 1ns / 1ps
module tb_flocking_velocity_rules_core;
  import fvr_pkg::*;

  // This pause covers an update still in flight after the last result has come.
  localparam int SETTLE_CYCLES = 600;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycle_count;
  int          hold_cycles;
  int          update_count;
  int          steer_count;
  int          config_phases;
  bit          idle_on;

  fvr_in_if  in_if();
  fvr_out_if out_if();

  flocking_velocity_rules_core dut (
    .clk(clk), .rst(rst), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fvr_flock_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts cycles and ends a run that hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("status: fail");
        $finish;
      end
    end
  end

  // The result side stalls in random bursts. A long hold requested by the
  // stimulus makes the queue fill so the core stalls its request input.
  initial begin
    int burst;
    burst = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else if (burst > 0) begin
        out_if.ready <= 1'b0;
        burst--;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0)
          burst = $urandom_range(1, 18);
      end
    end
  end

  // Offers one request and returns at the edge that accepts it. Ready is
  // looked at on the falling edge, so the handshake edge is known ahead.
  task automatic send_request(input logic op, input logic [2:0] mem,
                              input logic [23:0] px, input logic [23:0] pz);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.member <= mem;
    in_if.pos_x <= px;
    in_if.pos_z <= pz;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
    if (op == OP_STEER) steer_count++;
    else update_count++;
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops sending and waits until the core is idle.
  task automatic quiet_core();
    drop_valid();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Loads one whole register set; called only on an idle core.
  task automatic load_config(input logic [2:0] self_idx, input logic [23:0] tx,
                             input logic [23:0] tz, input logic [15:0] cw,
                             input logic [15:0] dw, input logic [15:0] aw,
                             input logic [15:0] rad, input logic [15:0] sep);
    quiet_core();
    write_reg(REG_SELF_INDEX, {21'd0, self_idx});
    write_reg(REG_TARGET_X, tx);
    write_reg(REG_TARGET_Z, tz);
    write_reg(REG_COH_WEIGHT, {8'd0, cw});
    write_reg(REG_DISP_WEIGHT, {8'd0, dw});
    write_reg(REG_ALIGN_WEIGHT, {8'd0, aw});
    write_reg(REG_COH_RADIUS, {8'd0, rad});
    write_reg(REG_SEP_LIMIT, {8'd0, sep});
    @(posedge clk);
    config_phases++;
  endtask

  // Positions are mostly near the origin so members come close and the
  // dispersion path is exercised; some span the whole range.
  function automatic logic [23:0] rand_pos();
    case ($urandom_range(0, 9))
      0, 1:    return 24'($urandom);
      2:       return 24'($urandom_range(0, 15)) - 24'd8;
      default: return 24'($urandom_range(0, 131071)) - 24'd65536;
    endcase
  endfunction

  task automatic random_requests(input int count);
    logic [2:0] mem;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_request(OP_STEER, 3'($urandom), rand_pos(), rand_pos());
      end else begin
        // Mostly members in the table; now and then one past the end.
        mem = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
        send_request(OP_UPDATE, mem, rand_pos(), rand_pos());
      end
    end
  endtask

  initial begin
    idle_on = 1'b1;
    hold_cycles = 0;
    update_count = 0;
    steer_count = 0;
    config_phases = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_SELF_INDEX;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.operation = OP_UPDATE;
    in_if.member = '0;
    in_if.pos_x = '0;
    in_if.pos_z = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on register defaults. A steer on an empty table sees
    // every member at zero distance, so every reciprocal saturates.
    send_request(OP_STEER, 3'd0, 24'd0, 24'd0);
    // First updates give zero speed; the repeat on member 1 gives real speed.
    send_request(OP_UPDATE, 3'd1, 24'h7FFFFF, 24'h800000);
    send_request(OP_UPDATE, 3'd1, 24'h800000, 24'h7FFFFF);
    send_request(OP_UPDATE, 3'd2, 24'd1, 24'hFFFFFF);
    send_request(OP_UPDATE, 3'd3, 24'd3, 24'd5);
    send_request(OP_UPDATE, 3'd4, 24'd0, 24'd0);
    // Members past the table are dropped.
    send_request(OP_UPDATE, 3'd5, 24'h123456, 24'h654321);
    send_request(OP_UPDATE, 3'd7, 24'hFFFFFF, 24'hFFFFFF);
    send_request(OP_STEER, 3'd7, 24'hFFFFFF, 24'hFFFFFF);
    send_request(OP_UPDATE, 3'd0, 24'd2, 24'd2);
    send_request(OP_STEER, 3'd0, 24'd0, 24'd0);
    send_request(OP_UPDATE, 3'd2, 24'd2, 24'd2);
    send_request(OP_STEER, 3'd0, 24'd0, 24'd0);

    // A self index past the table stands for the last member.
    load_config(3'd7, 24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'd0, 16'hFFFF);
    send_request(OP_STEER, 3'd0, 24'd0, 24'd0);
    send_request(OP_UPDATE, 3'd4, 24'h7FFFFF, 24'h7FFFFF);
    send_request(OP_STEER, 3'd0, 24'd0, 24'd0);
    load_config(3'd5, 24'h800000, 24'h7FFFFF, 16'd0, 16'd0, 16'd0,
                16'hFFFF, 16'd0);
    send_request(OP_STEER, 3'd0, 24'd0, 24'd0);

    // Random phases under changing register sets.
    load_config(3'd2, 24'd65536, 24'hFF0000, 16'd3932, 16'd131, 16'd6554,
                16'd13107, 16'd9830);
    random_requests(60);

    // Long receiver hold: the queue fills and the request input stalls.
    hold_cycles = 3000;
    random_requests(20);
    load_config(3'($urandom_range(0, 7)), 24'($urandom), 24'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    random_requests(80);
    load_config(3'd4, 24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF);
    random_requests(60);
    // Sender pause until every result has come back.
    quiet_core();
    load_config(3'($urandom_range(0, 4)), 24'($urandom), 24'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    random_requests(100);

    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    random_requests(60);
    drop_valid();

    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d updates and %0d steers over %0d register sets",
             update_count, steer_count, config_phases + 1);
    $display("mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
